>>> hw/rtl/iau_pkg.sv
// ----------------------------------------------------------------------------
// iau_pkg
// shared operation codes and default sizes for the interval arithmetic unit
// ----------------------------------------------------------------------------
package iau_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   typedef enum logic [3:0] {
      FUNC_EQUAL         = 4'd0,
      FUNC_ADD_INT       = 4'd1,
      FUNC_ADD_SCALAR    = 4'd2,
      FUNC_SUB_INT       = 4'd3,
      FUNC_SUB_SCALAR    = 4'd4,
      FUNC_MUL_INT       = 4'd5,
      FUNC_MUL_SCALAR    = 4'd6,
      FUNC_DIV_SCALAR    = 4'd7,
      FUNC_CONTAINS_ZERO = 4'd8
   } func_type;

endpackage

>>> hw/rtl/interval_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// interval_arithmetic_unit
// signed fixed point interval add, subtract, multiply, divide and tests
// ----------------------------------------------------------------------------
// rsp_valid pulses, alike for every operation, once the request has passed the
//   input register, the divider setup and steps, the sign and order stages and the output register
// throughput: one transfer per cycle; busy stays low, results are never held
// the short path is delayed to match the divider, one quotient bit per pipeline stage
// reset clears every valid bit in the pipeline; data registers are not reset
// ----------------------------------------------------------------------------
module interval_arithmetic_unit
   import iau_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [3:0]                   req_func,
   input  logic signed [DATA_WIDTH-1:0] req_a_lo,
   input  logic signed [DATA_WIDTH-1:0] req_a_hi,
   input  logic signed [DATA_WIDTH-1:0] req_b_lo,
   input  logic signed [DATA_WIDTH-1:0] req_b_hi,
   input  logic signed [DATA_WIDTH-1:0] req_scalar,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_res_lo,
   output logic signed [DATA_WIDTH-1:0] rsp_res_hi,
   output logic                         rsp_test_flag,
   output logic                         rsp_overflow,
   output logic                         rsp_div_zero
);

   localparam int W  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int QW = DATA_WIDTH + FRAC_BITS;   // quotient bits, one per divider stage
   localparam int PW = 2 * DATA_WIDTH;           // full product width

   localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};

   // one finished result on its way to the output
   typedef struct packed {
      logic signed [W-1:0] lo;
      logic signed [W-1:0] hi;
      logic                test;
      logic                ov;
      logic                dz;
   } rec_type;

   // true when a wide value lies in the result range
   function automatic logic fits_fn(input logic signed [PW-1:0] v);
      return (&v[PW-1:W-1]) | ~(|v[PW-1:W-1]);
   endfunction

   // saturate a wide value to the result range
   function automatic logic signed [W-1:0] clip_fn(input logic signed [PW-1:0] v);
      logic signed [W-1:0] r;
      if (fits_fn(v)) begin
         r = v[W-1:0];
      end else if (v[PW-1]) begin
         r = MIN_VAL;
      end else begin
         r = MAX_VAL;
      end
      return r;
   endfunction

   // magnitude of a signed end, as unsigned of the same width
   function automatic logic [W-1:0] mag_fn(input logic signed [W-1:0] v);
      return v[W-1] ? W'(-v) : W'(v);
   endfunction

   // -------------------------------------------------------------------------
   // input register
   // -------------------------------------------------------------------------
   logic                accept;
   logic                st0_valid_ff;
   func_type            st0_func_ff;
   logic signed [W-1:0] st0_a_lo_ff, st0_a_hi_ff, st0_b_lo_ff, st0_b_hi_ff, st0_s_ff;

   // the pipeline never stalls, so every start is taken
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         st0_valid_ff <= 1'b0;
      end else begin
         st0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         st0_func_ff <= func_type'(req_func);
         st0_a_lo_ff <= req_a_lo;
         st0_a_hi_ff <= req_a_hi;
         st0_b_lo_ff <= req_b_lo;
         st0_b_hi_ff <= req_b_hi;
         st0_s_ff    <= req_scalar;
      end
   end

   // -------------------------------------------------------------------------
   // add, subtract, multiply and test path: four stages, then a delay line
   // -------------------------------------------------------------------------

   // stage n1: sums, the four end products and the tests
   func_type             n1_func_ff;
   logic signed [W:0]    n1_sum_lo_ff, n1_sum_hi_ff, n1_sum_lo_in, n1_sum_hi_in;
   logic signed [PW-1:0] n1_p0_ff, n1_p1_ff, n1_p2_ff, n1_p3_ff;
   logic signed [W-1:0]  n1_m0_op, n1_m2_op;
   logic                 n1_eq_ff, n1_cz_ff, n1_sneg_ff;

   always_comb begin
      n1_sum_lo_in = '0;
      n1_sum_hi_in = '0;
      case (st0_func_ff)
         FUNC_ADD_INT: begin
            n1_sum_lo_in = (W+1)'(st0_a_lo_ff) + (W+1)'(st0_b_lo_ff);
            n1_sum_hi_in = (W+1)'(st0_a_hi_ff) + (W+1)'(st0_b_hi_ff);
         end
         FUNC_ADD_SCALAR: begin
            n1_sum_lo_in = (W+1)'(st0_a_lo_ff) + (W+1)'(st0_s_ff);
            n1_sum_hi_in = (W+1)'(st0_a_hi_ff) + (W+1)'(st0_s_ff);
         end
         FUNC_SUB_INT: begin
            n1_sum_lo_in = (W+1)'(st0_a_lo_ff) - (W+1)'(st0_b_hi_ff);
            n1_sum_hi_in = (W+1)'(st0_a_hi_ff) - (W+1)'(st0_b_lo_ff);
         end
         FUNC_SUB_SCALAR: begin
            n1_sum_lo_in = (W+1)'(st0_a_lo_ff) - (W+1)'(st0_s_ff);
            n1_sum_hi_in = (W+1)'(st0_a_hi_ff) - (W+1)'(st0_s_ff);
         end
         default: begin
            n1_sum_lo_in = '0;
            n1_sum_hi_in = '0;
         end
      endcase
   end

   // scalar multiply reuses the a_lo*b_lo and a_hi*b_lo multipliers
   assign n1_m0_op = (st0_func_ff == FUNC_MUL_SCALAR) ? st0_s_ff : st0_b_lo_ff;
   assign n1_m2_op = n1_m0_op;

   always_ff @(posedge clock) begin
      n1_func_ff   <= st0_func_ff;
      n1_sum_lo_ff <= n1_sum_lo_in;
      n1_sum_hi_ff <= n1_sum_hi_in;
      n1_p0_ff     <= PW'(st0_a_lo_ff) * PW'(n1_m0_op);
      n1_p1_ff     <= PW'(st0_a_lo_ff) * PW'(st0_b_hi_ff);
      n1_p2_ff     <= PW'(st0_a_hi_ff) * PW'(n1_m2_op);
      n1_p3_ff     <= PW'(st0_a_hi_ff) * PW'(st0_b_hi_ff);
      n1_eq_ff     <= (st0_a_lo_ff == st0_b_lo_ff) && (st0_a_hi_ff == st0_b_hi_ff);
      n1_cz_ff     <= (st0_a_lo_ff[W-1] || (st0_a_lo_ff == '0)) && !st0_a_hi_ff[W-1];
      n1_sneg_ff   <= st0_s_ff[W-1];
   end

   // stage n2: scale products down (floor), first level of min and max
   func_type             n2_func_ff;
   logic signed [PW-1:0] n2_lo_a_ff, n2_lo_b_ff, n2_hi_a_ff, n2_hi_b_ff;
   logic signed [PW-1:0] n2_lo_a_in, n2_lo_b_in, n2_hi_a_in, n2_hi_b_in;
   logic signed [PW-1:0] n2_sh0, n2_sh1, n2_sh2, n2_sh3;
   logic                 n2_eq_ff, n2_cz_ff;

   // the arithmetic shift is monotone, so it may come before the min and max
   assign n2_sh0 = n1_p0_ff >>> F;
   assign n2_sh1 = n1_p1_ff >>> F;
   assign n2_sh2 = n1_p2_ff >>> F;
   assign n2_sh3 = n1_p3_ff >>> F;

   always_comb begin
      n2_lo_a_in = '0;
      n2_lo_b_in = '0;
      n2_hi_a_in = '0;
      n2_hi_b_in = '0;
      case (n1_func_ff)
         FUNC_ADD_INT, FUNC_ADD_SCALAR, FUNC_SUB_INT, FUNC_SUB_SCALAR: begin
            n2_lo_a_in = PW'(n1_sum_lo_ff);
            n2_lo_b_in = PW'(n1_sum_lo_ff);
            n2_hi_a_in = PW'(n1_sum_hi_ff);
            n2_hi_b_in = PW'(n1_sum_hi_ff);
         end
         FUNC_MUL_INT: begin
            n2_lo_a_in = (n2_sh1 < n2_sh0) ? n2_sh1 : n2_sh0;
            n2_lo_b_in = (n2_sh3 < n2_sh2) ? n2_sh3 : n2_sh2;
            n2_hi_a_in = (n2_sh0 < n2_sh1) ? n2_sh1 : n2_sh0;
            n2_hi_b_in = (n2_sh2 < n2_sh3) ? n2_sh3 : n2_sh2;
         end
         FUNC_MUL_SCALAR: begin
            // negative scalar swaps the ends
            n2_lo_a_in = n1_sneg_ff ? n2_sh2 : n2_sh0;
            n2_lo_b_in = n2_lo_a_in;
            n2_hi_a_in = n1_sneg_ff ? n2_sh0 : n2_sh2;
            n2_hi_b_in = n2_hi_a_in;
         end
         default: begin
            n2_lo_a_in = '0;
            n2_lo_b_in = '0;
            n2_hi_a_in = '0;
            n2_hi_b_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n2_func_ff <= n1_func_ff;
      n2_lo_a_ff <= n2_lo_a_in;
      n2_lo_b_ff <= n2_lo_b_in;
      n2_hi_a_ff <= n2_hi_a_in;
      n2_hi_b_ff <= n2_hi_b_in;
      n2_eq_ff   <= n1_eq_ff;
      n2_cz_ff   <= n1_cz_ff;
   end

   // stage n3: second level of min and max
   func_type             n3_func_ff;
   logic signed [PW-1:0] n3_lo_ff, n3_hi_ff;
   logic                 n3_eq_ff, n3_cz_ff;

   always_ff @(posedge clock) begin
      n3_func_ff <= n2_func_ff;
      n3_lo_ff   <= (n2_lo_b_ff < n2_lo_a_ff) ? n2_lo_b_ff : n2_lo_a_ff;
      n3_hi_ff   <= (n2_hi_a_ff < n2_hi_b_ff) ? n2_hi_b_ff : n2_hi_a_ff;
      n3_eq_ff   <= n2_eq_ff;
      n3_cz_ff   <= n2_cz_ff;
   end

   // stage n4: saturate and form the result; the divide result is merged later
   rec_type n4_rec_in;
   rec_type rec_ff [0:QW-1];

   always_comb begin
      n4_rec_in = '0;
      case (n3_func_ff)
         FUNC_ADD_INT, FUNC_ADD_SCALAR, FUNC_SUB_INT, FUNC_SUB_SCALAR,
         FUNC_MUL_INT, FUNC_MUL_SCALAR: begin
            n4_rec_in.lo = clip_fn(n3_lo_ff);
            n4_rec_in.hi = clip_fn(n3_hi_ff);
            n4_rec_in.ov = ~fits_fn(n3_lo_ff) | ~fits_fn(n3_hi_ff);
         end
         FUNC_EQUAL: begin
            n4_rec_in.test = n3_eq_ff;
         end
         FUNC_CONTAINS_ZERO: begin
            n4_rec_in.test = n3_cz_ff;
         end
         default: begin
            n4_rec_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff[0] <= n4_rec_in;
   end

   // delay line that lines the short path up with the divider
   for (genvar j = 1; j < QW; j++) begin : g_rec_delay
      always_ff @(posedge clock) begin
         rec_ff[j] <= rec_ff[j-1];
      end
   end

   // -------------------------------------------------------------------------
   // divide path: setup, one restoring step per stage, sign, order
   // -------------------------------------------------------------------------
   logic          dv_valid_ff [0:QW];
   logic          dv_div_ff   [0:QW];
   logic          dv_szero_ff [0:QW];
   logic          dv_neg_lo_ff[0:QW];
   logic          dv_neg_hi_ff[0:QW];
   logic [W-1:0]  dv_den_ff   [0:QW];
   logic [QW-1:0] dv_nq_lo_ff [0:QW];   // numerator bits shifting out, quotient in
   logic [QW-1:0] dv_nq_hi_ff [0:QW];
   logic [W-1:0]  dv_rm_lo_ff [0:QW];
   logic [W-1:0]  dv_rm_hi_ff [0:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else begin
         dv_valid_ff[0] <= st0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      dv_div_ff[0]    <= (st0_func_ff == FUNC_DIV_SCALAR);
      dv_szero_ff[0]  <= (st0_s_ff == '0);
      dv_neg_lo_ff[0] <= st0_a_lo_ff[W-1] ^ st0_s_ff[W-1];
      dv_neg_hi_ff[0] <= st0_a_hi_ff[W-1] ^ st0_s_ff[W-1];
      dv_den_ff[0]    <= mag_fn(st0_s_ff);
      dv_nq_lo_ff[0]  <= QW'(mag_fn(st0_a_lo_ff)) << F;
      dv_nq_hi_ff[0]  <= QW'(mag_fn(st0_a_hi_ff)) << F;
      dv_rm_lo_ff[0]  <= '0;
      dv_rm_hi_ff[0]  <= '0;
   end

   for (genvar k = 1; k <= QW; k++) begin : g_div_step
      logic [W:0] trial_lo, trial_hi, diff_lo, diff_hi;

      assign trial_lo = {dv_rm_lo_ff[k-1], dv_nq_lo_ff[k-1][QW-1]};
      assign trial_hi = {dv_rm_hi_ff[k-1], dv_nq_hi_ff[k-1][QW-1]};
      assign diff_lo  = trial_lo - {1'b0, dv_den_ff[k-1]};
      assign diff_hi  = trial_hi - {1'b0, dv_den_ff[k-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else begin
            dv_valid_ff[k] <= dv_valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         dv_div_ff[k]    <= dv_div_ff[k-1];
         dv_szero_ff[k]  <= dv_szero_ff[k-1];
         dv_neg_lo_ff[k] <= dv_neg_lo_ff[k-1];
         dv_neg_hi_ff[k] <= dv_neg_hi_ff[k-1];
         dv_den_ff[k]    <= dv_den_ff[k-1];
         dv_rm_lo_ff[k]  <= diff_lo[W] ? trial_lo[W-1:0] : diff_lo[W-1:0];
         dv_rm_hi_ff[k]  <= diff_hi[W] ? trial_hi[W-1:0] : diff_hi[W-1:0];
         dv_nq_lo_ff[k]  <= {dv_nq_lo_ff[k-1][QW-2:0], ~diff_lo[W]};
         dv_nq_hi_ff[k]  <= {dv_nq_hi_ff[k-1][QW-2:0], ~diff_hi[W]};
      end
   end

   // stage a: apply the quotient sign
   logic              qa_valid_ff, qa_div_ff, qa_szero_ff;
   logic signed [QW:0] qa_lo_ff, qa_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         qa_valid_ff <= 1'b0;
      end else begin
         qa_valid_ff <= dv_valid_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      qa_div_ff   <= dv_div_ff[QW];
      qa_szero_ff <= dv_szero_ff[QW];
      qa_lo_ff    <= dv_neg_lo_ff[QW] ? -$signed({1'b0, dv_nq_lo_ff[QW]})
                                      :  $signed({1'b0, dv_nq_lo_ff[QW]});
      qa_hi_ff    <= dv_neg_hi_ff[QW] ? -$signed({1'b0, dv_nq_hi_ff[QW]})
                                      :  $signed({1'b0, dv_nq_hi_ff[QW]});
   end

   // stage b: put the two quotients in order
   logic               qb_valid_ff, qb_div_ff, qb_szero_ff;
   logic signed [QW:0] qb_lo_ff, qb_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         qb_valid_ff <= 1'b0;
      end else begin
         qb_valid_ff <= qa_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      qb_div_ff   <= qa_div_ff;
      qb_szero_ff <= qa_szero_ff;
      qb_lo_ff    <= (qa_hi_ff < qa_lo_ff) ? qa_hi_ff : qa_lo_ff;
      qb_hi_ff    <= (qa_hi_ff < qa_lo_ff) ? qa_lo_ff : qa_hi_ff;
   end

   // -------------------------------------------------------------------------
   // output register: divide result or the delayed short-path result
   // -------------------------------------------------------------------------
   logic                 rsp_valid_ff;
   rec_type              rsp_rec_ff, rsp_rec_in;
   logic signed [PW-1:0] qb_lo_wide, qb_hi_wide;

   assign qb_lo_wide = PW'(qb_lo_ff);
   assign qb_hi_wide = PW'(qb_hi_ff);

   always_comb begin
      rsp_rec_in = rec_ff[QW-1];
      if (qb_div_ff) begin
         rsp_rec_in = '0;
         if (qb_szero_ff) begin
            // divide by zero: full range, own flag
            rsp_rec_in.lo = MIN_VAL;
            rsp_rec_in.hi = MAX_VAL;
            rsp_rec_in.dz = 1'b1;
         end else begin
            rsp_rec_in.lo = clip_fn(qb_lo_wide);
            rsp_rec_in.hi = clip_fn(qb_hi_wide);
            rsp_rec_in.ov = ~fits_fn(qb_lo_wide) | ~fits_fn(qb_hi_wide);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= qb_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rec_ff <= rsp_rec_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_res_lo    = rsp_rec_ff.lo;
   assign rsp_res_hi    = rsp_rec_ff.hi;
   assign rsp_test_flag = rsp_rec_ff.test;
   assign rsp_overflow  = rsp_rec_ff.ov;
   assign rsp_div_zero  = rsp_rec_ff.dz;

   // -------------------------------------------------------------------------
   // assertions
   // -------------------------------------------------------------------------
   a_dz_no_ov : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_zero |-> !rsp_overflow && !rsp_test_flag
         && rsp_res_lo == MIN_VAL && rsp_res_hi == MAX_VAL)
      else $error("divide by zero result malformed");

   a_test_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_test_flag |-> rsp_res_lo == '0 && rsp_res_hi == '0
         && !rsp_overflow && !rsp_div_zero)
      else $error("test result carries arithmetic data");

   a_div_order : assert property (@(posedge clock) disable iff (reset)
      qb_valid_ff && qb_div_ff |=> rsp_res_lo <= rsp_res_hi)
      else $error("divide result ends out of order");

endmodule

>>> tb/sv/interval_arithmetic_unit_tb.sv
// ----------------------------------------------------------------------------
// interval_arithmetic_unit_tb
// drives directed and random interval operations, predicts each result in
// wide arithmetic and checks every strobed result against the oldest prediction
// ----------------------------------------------------------------------------
module interval_arithmetic_unit_tb
   import iau_pkg::*;
;

   localparam int DW = DATA_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int LATENCY = DW + FB + 4;

   typedef logic signed [DW-1:0] word_t;
   typedef logic signed [127:0]  wide_t;

   typedef struct packed {
      word_t res_lo;
      word_t res_hi;
      logic  test_flag;
      logic  overflow;
      logic  div_zero;
   } outcome_t;

   // expected outcomes in transfer order, with the predictor of the unit
   class interval_scoreboard;
      outcome_t pending[$];
      int       errors;

      function wide_t sat_end(wide_t v, ref logic ov);
         wide_t top;
         wide_t bot;
         top = (wide_t'(1) <<< (DW - 1)) - 1;
         bot = -(wide_t'(1) <<< (DW - 1));
         if (v > top) begin
            ov = 1'b1;
            return top;
         end
         if (v < bot) begin
            ov = 1'b1;
            return bot;
         end
         return v;
      endfunction

      // signed division truncating toward zero on magnitudes
      function wide_t div_end(word_t e, word_t s);
         wide_t n;
         wide_t d;
         wide_t q;
         n = wide_t'(e) <<< FB;
         d = wide_t'(s);
         q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
         return ((n < 0) != (d < 0)) ? -q : q;
      endfunction

      function void note_input(logic [3:0] func, word_t alo, word_t ahi,
                               word_t blo, word_t bhi, word_t s);
         outcome_t o;
         wide_t    lo;
         wide_t    hi;
         wide_t    p[4];
         wide_t    t;
         logic     arith;
         logic     ov;
         o = '0;
         lo = 0;
         hi = 0;
         arith = 1'b1;
         ov = 1'b0;
         case (func)
            FUNC_EQUAL: begin
               o.test_flag = (alo == blo) && (ahi == bhi);
               arith = 1'b0;
            end
            FUNC_ADD_INT: begin
               lo = wide_t'(alo) + wide_t'(blo);
               hi = wide_t'(ahi) + wide_t'(bhi);
            end
            FUNC_ADD_SCALAR: begin
               lo = wide_t'(alo) + wide_t'(s);
               hi = wide_t'(ahi) + wide_t'(s);
            end
            FUNC_SUB_INT: begin
               lo = wide_t'(alo) - wide_t'(bhi);
               hi = wide_t'(ahi) - wide_t'(blo);
            end
            FUNC_SUB_SCALAR: begin
               lo = wide_t'(alo) - wide_t'(s);
               hi = wide_t'(ahi) - wide_t'(s);
            end
            FUNC_MUL_INT: begin
               p[0] = wide_t'(alo) * wide_t'(blo);
               p[1] = wide_t'(alo) * wide_t'(bhi);
               p[2] = wide_t'(ahi) * wide_t'(blo);
               p[3] = wide_t'(ahi) * wide_t'(bhi);
               lo = p[0];
               hi = p[0];
               for (int k = 1; k < 4; k++) begin
                  if (p[k] < lo) lo = p[k];
                  if (p[k] > hi) hi = p[k];
               end
               lo = lo >>> FB;
               hi = hi >>> FB;
            end
            FUNC_MUL_SCALAR: begin
               // negative scalar swaps the ends
               if (s < 0) begin
                  lo = (wide_t'(ahi) * wide_t'(s)) >>> FB;
                  hi = (wide_t'(alo) * wide_t'(s)) >>> FB;
               end else begin
                  lo = (wide_t'(alo) * wide_t'(s)) >>> FB;
                  hi = (wide_t'(ahi) * wide_t'(s)) >>> FB;
               end
            end
            FUNC_DIV_SCALAR: begin
               if (s == 0) begin
                  o.div_zero = 1'b1;
                  lo = -(wide_t'(1) <<< (DW - 1));
                  hi = (wide_t'(1) <<< (DW - 1)) - 1;
               end else begin
                  lo = div_end(alo, s);
                  hi = div_end(ahi, s);
                  if (hi < lo) begin
                     t = lo;
                     lo = hi;
                     hi = t;
                  end
               end
            end
            FUNC_CONTAINS_ZERO: begin
               o.test_flag = (alo <= 0) && (ahi >= 0);
               arith = 1'b0;
            end
            default: arith = 1'b0;
         endcase
         if (arith) begin
            o.res_lo = word_t'(sat_end(lo, ov));
            o.res_hi = word_t'(sat_end(hi, ov));
            o.overflow = ov;
         end
         pending.push_back(o);
      endfunction

      function void check_result(outcome_t got);
         outcome_t want;
         if (pending.size() == 0) begin
            $error("result with no outstanding transfer");
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.res_lo !== want.res_lo) begin
            $error("res_lo expected %h actual %h", want.res_lo, got.res_lo);
            errors++;
         end
         if (got.res_hi !== want.res_hi) begin
            $error("res_hi expected %h actual %h", want.res_hi, got.res_hi);
            errors++;
         end
         if (got.test_flag !== want.test_flag) begin
            $error("test_flag expected %b actual %b", want.test_flag, got.test_flag);
            errors++;
         end
         if (got.overflow !== want.overflow) begin
            $error("overflow expected %b actual %b", want.overflow, got.overflow);
            errors++;
         end
         if (got.div_zero !== want.div_zero) begin
            $error("div_zero expected %b actual %b", want.div_zero, got.div_zero);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [3:0] req_func;
   word_t      req_a_lo;
   word_t      req_a_hi;
   word_t      req_b_lo;
   word_t      req_b_hi;
   word_t      req_scalar;
   logic       rsp_valid;
   word_t      rsp_res_lo;
   word_t      rsp_res_hi;
   logic       rsp_test_flag;
   logic       rsp_overflow;
   logic       rsp_div_zero;

   interval_scoreboard board;
   int idle_pct;   // percent of cycles the sender holds off

   interval_arithmetic_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_a_lo(req_a_lo), .req_a_hi(req_a_hi),
      .req_b_lo(req_b_lo), .req_b_hi(req_b_hi), .req_scalar(req_scalar),
      .rsp_valid(rsp_valid), .rsp_res_lo(rsp_res_lo), .rsp_res_hi(rsp_res_hi),
      .rsp_test_flag(rsp_test_flag), .rsp_overflow(rsp_overflow),
      .rsp_div_zero(rsp_div_zero)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // every strobed result is a transfer; the receiver cannot stall
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_result({rsp_res_lo, rsp_res_hi, rsp_test_flag,
                             rsp_overflow, rsp_div_zero});
      end
   end

   // one transfer: optional idle cycles, then start held until accepted
   task automatic send_item(logic [3:0] func, word_t alo, word_t ahi,
                            word_t blo, word_t bhi, word_t s);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_func <= func;
      req_a_lo <= alo;
      req_a_hi <= ahi;
      req_b_lo <= blo;
      req_b_hi <= bhi;
      req_scalar <= s;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_input(func, alo, ahi, blo, bhi, s);
   endtask

   // interesting end values: extremes, zero, one, small and random
   function automatic word_t pick_end();
      case ($urandom_range(9))
         0: return {1'b1, {(DW-1){1'b0}}};
         1: return {1'b0, {(DW-1){1'b1}}};
         2: return '0;
         3: return word_t'(1) <<< FB;
         4: return -(word_t'(1) <<< FB);
         5: return word_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         6: return word_t'(-1);
         default: return word_t'($urandom);
      endcase
   endfunction

   task automatic send_random();
      logic [3:0] func;
      word_t      alo;
      word_t      ahi;
      word_t      blo;
      word_t      bhi;
      word_t      s;
      func = ($urandom_range(19) == 0) ? 4'($urandom_range(15))
                                       : 4'($urandom_range(8));
      alo = pick_end();
      ahi = pick_end();
      // mostly well-formed intervals, sometimes reversed
      if (ahi < alo && $urandom_range(3) != 0) {alo, ahi} = {ahi, alo};
      blo = ($urandom_range(7) == 0) ? alo : pick_end();
      bhi = ($urandom_range(7) == 0) ? ahi : pick_end();
      if (bhi < blo && $urandom_range(3) != 0) {blo, bhi} = {bhi, blo};
      s = ($urandom_range(9) == 0) ? word_t'(0) : pick_end();
      send_item(func, alo, ahi, blo, bhi, s);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      word_t mx;
      word_t mn;
      word_t one;
      board = new();
      mx = {1'b0, {(DW-1){1'b1}}};
      mn = {1'b1, {(DW-1){1'b0}}};
      one = word_t'(1) <<< FB;
      idle_pct = 0;
      reset = 1'b1;
      start = 1'b0;
      req_func = '0;
      req_a_lo = '0;
      req_a_hi = '0;
      req_b_lo = '0;
      req_b_hi = '0;
      req_scalar = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: each operation, extremes, saturation, zero divide, tests, undefined codes
      send_item(FUNC_EQUAL, one, mx, one, mx, 0);
      send_item(FUNC_EQUAL, one, mx, one, mn, 0);
      send_item(FUNC_ADD_INT, mx, mx, mx, one, 0);
      send_item(FUNC_ADD_INT, mn, mn, mn, -one, 0);
      send_item(FUNC_ADD_SCALAR, -one, one, 0, 0, mx);
      send_item(FUNC_SUB_INT, mn, mx, mn, mx, 0);
      send_item(FUNC_SUB_SCALAR, mn, one, 0, 0, one);
      send_item(FUNC_MUL_INT, mn, mx, mn, mx, 0);
      send_item(FUNC_MUL_INT, -one, 3 * one, -2 * one, one, 0);
      send_item(FUNC_MUL_INT, -1, 1, -1, 1, 0);
      send_item(FUNC_MUL_SCALAR, -one, 2 * one, 0, 0, -3 * one);
      send_item(FUNC_MUL_SCALAR, mn, mx, 0, 0, mn);
      send_item(FUNC_MUL_SCALAR, -1, 1, 0, 0, 1);
      send_item(FUNC_DIV_SCALAR, -one, 2 * one, 0, 0, 0);
      send_item(FUNC_DIV_SCALAR, -one, 2 * one, 0, 0, -3 * one);
      send_item(FUNC_DIV_SCALAR, mn, mx, 0, 0, 1);
      send_item(FUNC_DIV_SCALAR, mn, mx, 0, 0, -1);
      send_item(FUNC_CONTAINS_ZERO, 0, one, 0, 0, 0);
      send_item(FUNC_CONTAINS_ZERO, -one, 0, 0, 0, 0);
      send_item(FUNC_CONTAINS_ZERO, one, mx, 0, 0, 0);
      send_item(FUNC_CONTAINS_ZERO, one, -one, 0, 0, 0);
      send_item(4'd9, mx, mx, mx, mx, mx);
      send_item(4'd15, mn, mn, mn, mn, mn);

      // pause until every outstanding result is back
      drain();

      // random phases: back to back, sparse sender, no receiver stall, mixed
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: idle_pct = 0;
            1: idle_pct = 73;
            3: idle_pct = 14;
            default: idle_pct = 0;
         endcase
         for (int n = 0; n < 310; n++) send_random();
      end

      drain();
      repeat (LATENCY + 8) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog well beyond the slowest correct run
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
